[sv/glmd_pkg.sv]
// Shared types and constants for the grid local maximum detector.
// Used by glmd_front, glmd_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package glmd_pkg;

	localparam int CFG_BITS    = 6;   // width of each configuration register
	localparam int POS_BITS    = 5;   // width of the reported row and column
	localparam int RES_SLOTS   = 3;   // results one item can cause
	localparam int QUEUE_DEPTH = 4;   // jobs held between front and back

	// result slots of one job, in delivery order
	localparam int SLOT_ABOVE = 0;    // cell one row up, same column
	localparam int SLOT_LEFT  = 1;    // last row, cell to the left
	localparam int SLOT_HERE  = 2;    // last row, final cell itself

	typedef enum logic {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_idx_t;

	// one accepted item's worth of reports, minus the values
	typedef struct packed {
		logic [RES_SLOTS-1:0]                mask;
		logic [RES_SLOTS-1:0]                peak;
		logic                                frame_last;
		logic [RES_SLOTS-1:0][POS_BITS-1:0] row;
		logic [RES_SLOTS-1:0][POS_BITS-1:0] col;
	} job_t;

endpackage

[sv/glmd_queue.sv]
// Small register FIFO that carries jobs from the front to the back.
// Generic over data width and depth; no package dependency.
`timescale 1ns / 1ps

module glmd_queue #(
	parameter int DATA_BITS = 8,
	parameter int DEPTH     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] slot_q [DEPTH];
	logic [PB-1:0]        head_q, tail_q;
	logic [CB-1:0]        count_q;
	logic                 do_push, do_pop;

	assign full      = (count_q == CB'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[head_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PB'(DEPTH - 1)) ? '0 : tail_q + PB'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == PB'(DEPTH - 1)) ? '0 : head_q + PB'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CB'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

endmodule

[sv/glmd_front.sv]
// Front end: configuration, raster counters, line store and peak tests.
// An accepted item owing reports is one job of up to three. Uses glmd_pkg.
`timescale 1ns / 1ps

module glmd_front #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  logic                                             cfg_index,
	input  logic [glmd_pkg::CFG_BITS-1:0]                    cfg_data,
	input  logic signed [VALUE_BITS-1:0]                     cell_value,
	input  logic                                             in_valid,
	output logic                                             in_stall,
	input  logic                                             q_full,
	output logic                                             push,
	output glmd_pkg::job_t                                   job,
	output logic [glmd_pkg::RES_SLOTS-1:0][VALUE_BITS-1:0]   job_vals
);

	localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WB       = $clog2(MAX_WIDTH + 1);
	localparam int HB       = $clog2(MAX_HEIGHT + 1);
	localparam int PB       = glmd_pkg::POS_BITS;

	logic [WB-1:0]       width_q;
	logic [HB-1:0]       height_q;
	logic [COL_BITS-1:0] col_q, col_next, ra0, ra1;
	logic [ROW_BITS-1:0] row_q, row_next;
	logic [WB-1:0]       col_p1, ra0_p1;
	logic [HB-1:0]       row_p1;
	logic                primed_q;
	logic                accept, last_col, last_row, has_right;

	// line stores: row r-1 and row r-2, one entry per column
	logic signed [VALUE_BITS-1:0] above_mem [MAX_WIDTH];
	logic signed [VALUE_BITS-1:0] two_mem   [MAX_WIDTH];
	logic signed [VALUE_BITS-1:0] rd0_above_q, rd0_two_q, rd1_above_q;
	logic signed [VALUE_BITS-1:0] above_prev_q, prev_cell_q, prev2_cell_q;
	logic                          rd_en;

	logic pk_a, pk_b, pk_c;

	assign in_stall = !primed_q || q_full;
	assign accept   = in_valid && !in_stall;

	assign col_p1    = WB'(col_q) + WB'(1);
	assign row_p1    = HB'(row_q) + HB'(1);
	assign last_col  = (col_p1 == width_q);
	assign last_row  = (row_p1 == height_q);
	assign has_right = (col_p1 < width_q);

	assign col_next = last_col ? '0 : COL_BITS'(col_p1);
	assign row_next = !last_col ? row_q : (last_row ? '0 : ROW_BITS'(row_p1));

	// reads are issued for the next position, so data waits in registers
	assign rd_en  = accept || !primed_q;
	assign ra0    = accept ? col_next : col_q;
	assign ra0_p1 = WB'(ra0) + WB'(1);
	assign ra1    = (ra0_p1 >= WB'(MAX_WIDTH)) ? '0 : COL_BITS'(ra0_p1);

	always_ff @(posedge clk) begin
		if (accept) begin
			above_mem[col_q] <= cell_value;
			two_mem[col_q]   <= rd0_above_q;
		end
		if (rd_en) begin
			// write-first on a same-entry hit (narrow grids)
			rd0_above_q <= (accept && ra0 == col_q) ? cell_value  : above_mem[ra0];
			rd0_two_q   <= (accept && ra0 == col_q) ? rd0_above_q : two_mem[ra0];
			rd1_above_q <= (accept && ra1 == col_q) ? cell_value  : above_mem[ra1];
		end
		if (accept) begin
			above_prev_q <= rd0_above_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WB'(MAX_WIDTH);
			height_q     <= HB'(MAX_HEIGHT);
			col_q        <= '0;
			row_q        <= '0;
			primed_q     <= 1'b0;
			prev_cell_q  <= '0;
			prev2_cell_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				glmd_pkg::CFG_GRID_WIDTH: begin
					if (cfg_data == '0) begin
						width_q <= WB'(1);
					end else if (int'(cfg_data) > MAX_WIDTH) begin
						width_q <= WB'(MAX_WIDTH);
					end else begin
						width_q <= WB'(cfg_data);
					end
				end
				glmd_pkg::CFG_GRID_HEIGHT: begin
					if (cfg_data == '0) begin
						height_q <= HB'(1);
					end else if (int'(cfg_data) > MAX_HEIGHT) begin
						height_q <= HB'(MAX_HEIGHT);
					end else begin
						height_q <= HB'(cfg_data);
					end
				end
				default: begin
				end
			endcase
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			primed_q <= 1'b1;
			if (accept) begin
				col_q        <= col_next;
				row_q        <= row_next;
				prev_cell_q  <= cell_value;
				prev2_cell_q <= prev_cell_q;
			end
		end
	end

	// cell one row up: down neighbour is the new item
	assign pk_a = (!(row_q > ROW_BITS'(1)) || rd0_above_q > rd0_two_q)
		&& (rd0_above_q > cell_value)
		&& (col_q == '0 || rd0_above_q > above_prev_q)
		&& (!has_right || rd0_above_q > rd1_above_q);

	// last row, left cell: right neighbour is the new item
	assign pk_b = (row_q == '0 || prev_cell_q > above_prev_q)
		&& (!(col_q > COL_BITS'(1)) || prev_cell_q > prev2_cell_q)
		&& (prev_cell_q > cell_value);

	// final cell of the frame
	assign pk_c = (row_q == '0 || cell_value > rd0_above_q)
		&& (col_q == '0 || cell_value > prev_cell_q);

	always_comb begin
		job = '0;
		job.mask[glmd_pkg::SLOT_ABOVE] = (row_q != '0);
		job.mask[glmd_pkg::SLOT_LEFT]  = last_row && (col_q != '0);
		job.mask[glmd_pkg::SLOT_HERE]  = last_row && last_col;
		job.peak[glmd_pkg::SLOT_ABOVE] = pk_a;
		job.peak[glmd_pkg::SLOT_LEFT]  = pk_b;
		job.peak[glmd_pkg::SLOT_HERE]  = pk_c;
		job.frame_last = last_row && last_col;
		job.row[glmd_pkg::SLOT_ABOVE] = PB'(row_q - ROW_BITS'(1));
		job.row[glmd_pkg::SLOT_LEFT]  = PB'(row_q);
		job.row[glmd_pkg::SLOT_HERE]  = PB'(row_q);
		job.col[glmd_pkg::SLOT_ABOVE] = PB'(col_q);
		job.col[glmd_pkg::SLOT_LEFT]  = PB'(col_q - COL_BITS'(1));
		job.col[glmd_pkg::SLOT_HERE]  = PB'(col_q);
		job_vals[glmd_pkg::SLOT_ABOVE] = rd0_above_q;
		job_vals[glmd_pkg::SLOT_LEFT]  = prev_cell_q;
		job_vals[glmd_pkg::SLOT_HERE]  = cell_value;
	end

	assign push = accept && (job.mask != '0);

endmodule

[sv/glmd_back.sv]
// Back end: takes one job at a time and delivers its reports in order.
// Output fields are muxed from registered job data. Uses glmd_pkg.
`timescale 1ns / 1ps

module glmd_back #(
	parameter int VALUE_BITS = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             q_valid,
	input  glmd_pkg::job_t                                   q_job,
	input  logic [glmd_pkg::RES_SLOTS-1:0][VALUE_BITS-1:0]   q_vals,
	output logic                                             pop,
	output logic signed [VALUE_BITS-1:0]                     report_value,
	output logic [glmd_pkg::POS_BITS-1:0]                    report_row,
	output logic [glmd_pkg::POS_BITS-1:0]                    report_col,
	output logic                                             is_peak,
	output logic                                             run_last,
	output logic                                             frame_last,
	output logic                                             out_valid,
	input  logic                                             out_stall
);

	localparam int SB = $clog2(glmd_pkg::RES_SLOTS);
	localparam int RS = glmd_pkg::RES_SLOTS;

	glmd_pkg::job_t                                 job_q;
	logic [glmd_pkg::RES_SLOTS-1:0][VALUE_BITS-1:0] vals_q;
	logic [glmd_pkg::RES_SLOTS-1:0]                 left_q, low_bit;
	logic [SB-1:0]                                  sel;
	logic                                           take, load;

	// lowest pending slot goes out first
	always_comb begin
		if (left_q[glmd_pkg::SLOT_ABOVE]) begin
			sel = SB'(glmd_pkg::SLOT_ABOVE);
		end else if (left_q[glmd_pkg::SLOT_LEFT]) begin
			sel = SB'(glmd_pkg::SLOT_LEFT);
		end else begin
			sel = SB'(glmd_pkg::SLOT_HERE);
		end
	end

	assign low_bit   = left_q & (~left_q + RS'(1));
	assign out_valid = (left_q != '0);
	assign run_last  = ((left_q & (left_q - RS'(1))) == '0);

	assign report_value = vals_q[sel];
	assign report_row   = job_q.row[sel];
	assign report_col   = job_q.col[sel];
	assign is_peak      = job_q.peak[sel];
	assign frame_last   = job_q.frame_last
		&& (sel == SB'(glmd_pkg::SLOT_HERE));

	assign take = out_valid && !out_stall;
	assign load = q_valid && (!out_valid || (take && run_last));
	assign pop  = load;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q  <= q_job;
			vals_q <= q_vals;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= q_job.mask;
		end else if (take) begin
			left_q <= left_q & ~low_bit;
		end
	end

endmodule

[sv/grid_local_maximum_detect.sv]
// Top level of the four-neighbour grid local maximum detector.
// Instantiates glmd_front, glmd_queue and glmd_back; uses glmd_pkg.
`timescale 1ns / 1ps

// Usage
//  - Input channel: one signed cell_value per item, raster order, row by row.
//    Taken at a rising edge with in_valid high and in_stall low.
//  - Output channel: one report per item moved (value, row, column, peak flag,
//    run_last on the last report of an input, frame_last on the final cell).
//    Taken at a rising edge with out_valid high and out_stall low.
//  - Config: cfg_we with cfg_index (0 width, 1 height) and cfg_data, only
//    while idle. A write restarts the frame; the line store keeps its data.
//  - Throughput: one item per cycle while in_stall is low. Rows other than
//    the last give at most one report per item; in the last row an item
//    gives up to three, and the back end delivers one report per cycle
//    while out_stall is low, so the output port sets the pace there and the
//    job queue fills. From a taken item: job queue write, back end load,
//    then the report is valid and can leave at the next edge at the earliest.
//  - Reset and config: in_stall is high for one cycle after reset and after
//    each config write while the line store prefetch is primed.
//  - Receiver stall: the current report holds; the front keeps taking items
//    until the job queue is full, then raises in_stall.

module grid_local_maximum_detect #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [glmd_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic signed [VALUE_BITS-1:0]     cell_value,
	input  logic                             in_valid,
	output logic                             in_stall,
	output logic signed [VALUE_BITS-1:0]     report_value,
	output logic [glmd_pkg::POS_BITS-1:0]    report_row,
	output logic [glmd_pkg::POS_BITS-1:0]    report_col,
	output logic                             is_peak,
	output logic                             run_last,
	output logic                             frame_last,
	output logic                             out_valid,
	input  logic                             out_stall
);

	localparam int VALS_BITS = glmd_pkg::RES_SLOTS * VALUE_BITS;
	localparam int JOB_BITS  = $bits(glmd_pkg::job_t);
	localparam int Q_BITS    = JOB_BITS + VALS_BITS;

	glmd_pkg::job_t                                 f_job, b_job;
	logic [glmd_pkg::RES_SLOTS-1:0][VALUE_BITS-1:0] f_vals, b_vals;
	logic [Q_BITS-1:0]                              q_out;
	logic                                           q_push, q_full, q_pop, q_valid;

	// front: counters, line store and the three peak tests
	glmd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_value (cell_value),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (q_push),
		.job        (f_job),
		.job_vals   (f_vals)
	);

	// jobs wait here so each side can stall on its own
	glmd_queue #(
		.DATA_BITS (Q_BITS),
		.DEPTH     (glmd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_vals, f_job}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	assign b_job  = q_out[JOB_BITS-1:0];
	assign b_vals = q_out[Q_BITS-1:JOB_BITS];

	// back: one report per cycle while out_stall is low, in slot order
	glmd_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (b_job),
		.q_vals       (b_vals),
		.pop          (q_pop),
		.report_value (report_value),
		.report_row   (report_row),
		.report_col   (report_col),
		.is_peak      (is_peak),
		.run_last     (run_last),
		.frame_last   (frame_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

`ifndef SYNTHESIS
	// the front never offers a job the queue cannot hold
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	// the final cell closes the run of its item
	a_frame_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> run_last)
		else $error("frame_last without run_last");

	// a config write restarts the frame and re-primes the line store read
	a_cfg_primes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken before line store prefetch after config");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the grid local maximum detector.
// Holds its own four-neighbour peak predictor; needs glmd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int VBITS    = 16;   // cell value width at the default build
	localparam int GRID_MAX = 32;   // MAX_WIDTH and MAX_HEIGHT of the build
	localparam int PAD_CYC  = 6;    // settle time after the last report
	localparam int HOLD_CYC = 80;   // long receiver hold-off
	localparam int CFG_W    = glmd_pkg::CFG_BITS;
	localparam int POS_W    = glmd_pkg::POS_BITS;

	// one report as the block should deliver it
	typedef struct {
		logic signed [VBITS-1:0] value;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic                    peak;
		logic                    run_end;
		logic                    frame_end;
	} grid_report_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// block inputs, all known from time zero
	logic                    cfg_we     = 1'b0;
	logic                    cfg_index  = glmd_pkg::CFG_GRID_WIDTH;
	logic [CFG_W-1:0]        cfg_data   = '0;
	logic signed [VBITS-1:0] cell_value = '0;
	logic                    in_valid   = 1'b0;
	logic                    out_stall  = 1'b0;

	// block outputs
	logic                    in_stall;
	logic signed [VBITS-1:0] report_value;
	logic [POS_W-1:0]        report_row;
	logic [POS_W-1:0]        report_col;
	logic                    is_peak;
	logic                    run_last;
	logic                    frame_last;
	logic                    out_valid;

	grid_local_maximum_detect dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_value   (cell_value),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.report_value (report_value),
		.report_row   (report_row),
		.report_col   (report_col),
		.is_peak      (is_peak),
		.run_last     (run_last),
		.frame_last   (frame_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	// ------------------------------------------------------------------
	// Peak predictor: own copy of the registers, counters and line stores
	// ------------------------------------------------------------------
	logic [CFG_W-1:0]        grid_w_reg = CFG_W'(GRID_MAX);
	logic [CFG_W-1:0]        grid_h_reg = CFG_W'(GRID_MAX);
	logic signed [VBITS-1:0] line_up  [GRID_MAX];   // row r-1
	logic signed [VBITS-1:0] line_up2 [GRID_MAX];   // row r-2
	logic signed [VBITS-1:0] left1 = '0;            // cell (r,c-1)
	logic signed [VBITS-1:0] left2 = '0;            // cell (r,c-2)
	int                      next_row = 0;
	int                      next_col = 0;

	grid_report_t pending_reports[$];   // reports still owed by the block

	// bookkeeping
	int  error_count   = 0;
	int  items_sent    = 0;
	int  reports_seen  = 0;
	int  settings_used = 0;
	bit  input_live    = 1'b0;   // in_valid is high and its item was just taken
	bit  idle_on       = 1'b1;   // random sender gaps
	bit  stall_quiet   = 1'b0;   // no random receiver stalls
	bit  long_hold_req = 1'b0;   // ask the stall process for one long hold-off

	// register value as the block uses it: 0 acts as 1, above max clamps
	function automatic int eff_size(input logic [CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > GRID_MAX)
			return GRID_MAX;
		return int'(r);
	endfunction

	// a missing neighbour never blocks a peak
	function automatic bit beats(input logic signed [VBITS-1:0] v, input bit present,
			input logic signed [VBITS-1:0] nb);
		return !present || (v > nb);
	endfunction

	function automatic grid_report_t make_report(input logic signed [VBITS-1:0] v,
			input int r, input int c, input bit pk, input bit fl);
		grid_report_t rep;
		rep.value     = v;
		rep.row       = POS_W'(r);
		rep.col       = POS_W'(c);
		rep.peak      = pk;
		rep.run_end   = 1'b0;
		rep.frame_end = fl;
		return rep;
	endfunction

	// Work out the reports that one accepted cell releases and queue them.
	// Above the last row a cell settles the one above it; in the last row
	// the left neighbour is settled too, and the final cell settles itself.
	task automatic predict_reports(input logic signed [VBITS-1:0] x);
		int                      w, h, r, c, n;
		bit                      last_row, pk;
		logic signed [VBITS-1:0] v;
		grid_report_t            batch [glmd_pkg::RES_SLOTS];
		w = eff_size(grid_w_reg);
		h = eff_size(grid_h_reg);
		r = next_row;
		c = next_col;
		n = 0;
		if (r >= h || c >= w) begin
			r = 0;
			c = 0;
		end
		last_row = (r == h - 1);

		if (r > 0) begin
			v  = line_up[c];
			pk = beats(v, r > 1, line_up2[c]) && beats(v, 1'b1, x) &&
				beats(v, c > 0, line_up2[(c > 0) ? c - 1 : 0]) &&
				beats(v, c + 1 < w, line_up[(c + 1 < w) ? c + 1 : c]);
			batch[n] = make_report(v, r - 1, c, pk, 1'b0);
			n++;
		end
		if (last_row && c > 0) begin
			v  = left1;
			pk = beats(v, r > 0, line_up2[c - 1]) && beats(v, c > 1, left2) &&
				beats(v, 1'b1, x);
			batch[n] = make_report(v, r, c - 1, pk, 1'b0);
			n++;
		end
		if (last_row && c == w - 1) begin
			pk = beats(x, r > 0, line_up[c]) && beats(x, c > 0, left1);
			batch[n] = make_report(x, r, c, pk, 1'b1);
			n++;
		end
		if (n > 0)
			batch[n - 1].run_end = 1'b1;
		for (int i = 0; i < n; i++)
			pending_reports.push_back(batch[i]);

		line_up2[c] = line_up[c];
		line_up[c]  = x;
		left2       = left1;
		left1       = x;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	// ------------------------------------------------------------------
	// Output side: receiver stall and report check
	// ------------------------------------------------------------------

	// Random stall bursts, plus one long hold-off on request
	// so that the job queue fills and the block stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!stall_quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Outputs and out_stall are sampled before this edge's updates land.
	always @(posedge clk) begin : report_check
		grid_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("report with nothing pending: value %0d row %0d col %0d",
					report_value, report_row, report_col);
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("report_value", want.value, report_value);
				compare_field("report_row", want.row, report_row);
				compare_field("report_col", want.col, report_col);
				compare_field("is_peak", want.peak, is_peak);
				compare_field("run_last", want.run_end, run_last);
				compare_field("frame_last", want.frame_end, frame_last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one cell and wait for it to be taken. in_valid is left high on
	// return so that a following item goes out back to back; anything else
	// that lets time pass calls release_input first.
	task automatic send_cell(input logic signed [VBITS-1:0] v);
		if (input_live) begin
			if (idle_on && $urandom_range(0, 6) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				in_valid <= 1'b1;
			end
		end else begin
			if (idle_on && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) @(posedge clk);
			in_valid <= 1'b1;
		end
		cell_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		predict_reports(v);
		items_sent++;
		input_live = 1'b1;
	endtask

	task automatic release_input();
		if (input_live) begin
			in_valid <= 1'b0;
			@(posedge clk);
			input_live = 1'b0;
		end
	endtask

	// sender pause: nothing offered until every owed report is in
	task automatic wait_for_reports();
		release_input();
		while (pending_reports.size() != 0)
			@(posedge clk);
		// first-row items owe nothing but may still be in flight
		repeat (PAD_CYC) @(posedge clk);
	endtask

	// Write both registers while idle; each write restarts the frame.
	task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_for_reports();
		cfg_we    <= 1'b1;
		cfg_index <= glmd_pkg::CFG_GRID_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		grid_w_reg = w;
		next_row   = 0;
		next_col   = 0;
		cfg_index <= glmd_pkg::CFG_GRID_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		grid_h_reg = h;
		next_row   = 0;
		next_col   = 0;
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// flavour 0: full range, 1: tiny range (lots of ties), 2: extremes
	function automatic logic signed [VBITS-1:0] pick_cell(input int flavour);
		int t;
		case (flavour)
			0: return VBITS'($urandom);
			1: begin
				t = $urandom_range(0, 4);
				return VBITS'(t - 2);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return -16'sd1;
				endcase
			end
		endcase
	endfunction

	task automatic send_frame(input int count, input int flavour);
		for (int i = 0; i < count; i++)
			send_cell(pick_cell(flavour));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked grids: default size first row, single cell, 3x3 with a
	// clear peak and ties, all-equal 2x2, zero registers acting as one.
	task automatic test_directed();
		// reset size 32x32: first row only stores, no reports owed
		send_cell(16'sh7fff);
		send_cell(16'sh8000);
		send_cell(16'sh0000);

		// one-cell grid: every cell is its own frame and a peak
		set_grid(6'd1, 6'd1);
		send_cell(16'sh7fff);
		send_cell(16'sh8000);

		// 3x3 with extremes on the border, a vertical tie and a centre dip
		set_grid(6'd3, 6'd3);
		send_cell(-16'sd5);
		send_cell(16'sh7fff);
		send_cell(-16'sd5);
		send_cell(16'sd3);
		send_cell(16'sd7);
		send_cell(16'sd3);
		send_cell(16'sh8000);
		send_cell(16'sd7);
		send_cell(16'sh7fff);

		// all ties: no cell can be a peak
		set_grid(6'd2, 6'd2);
		repeat (4) send_cell(16'sd4);

		// zero in both registers acts as a one-cell grid
		set_grid(6'd0, 6'd0);
		send_cell(-16'sd1);
	endtask

	// Full-size and out-of-range settings once each, then mostly small
	// random grids with now and then a frame cut short before the rewrite.
	task automatic test_random_frames();
		logic [CFG_W-1:0] ew [6] = '{6'd63, 6'd7, 6'd2, 6'd0, 6'd5, 6'd1};
		logic [CFG_W-1:0] eh [6] = '{6'd2, 6'd1, 6'd3, 6'd4, 6'd1, 6'd63};
		logic [CFG_W-1:0] w, h;
		int               start, full, count;
		start = items_sent;
		for (int i = 0; i < 6; i++) begin
			set_grid(ew[i], eh[i]);
			send_frame(eff_size(ew[i]) * eff_size(eh[i]), (i == 4) ? 2 : 0);
		end
		while (items_sent - start < 150) begin
			w = CFG_W'($urandom_range(1, 6));
			h = CFG_W'($urandom_range(1, 6));
			if ($urandom_range(0, 9) == 0)
				w = ($urandom_range(0, 1) == 0) ? 6'd0 :
					CFG_W'($urandom_range(33, 63));
			if ($urandom_range(0, 9) == 0)
				h = ($urandom_range(0, 1) == 0) ? 6'd0 :
					CFG_W'($urandom_range(33, 63));
			// keep clamped heights on narrow grids so the run stays short
			if (eff_size(h) > 8 && eff_size(w) > 2)
				w = 6'd2;
			if (eff_size(w) > 8 && eff_size(h) > 2)
				h = 6'd2;
			set_grid(w, h);
			full  = eff_size(w) * eff_size(h);
			count = ($urandom_range(0, 5) == 0 && full > 1) ?
				$urandom_range(1, full - 1) : full * $urandom_range(1, 2);
			send_frame(count, $urandom_range(0, 2));
		end
	endtask

	// Receiver holds off while the sender keeps offering cells of a 5x4 grid;
	// its last-row items owe up to three reports each, so the queue fills.
	task automatic test_long_hold();
		set_grid(6'd5, 6'd4);
		long_hold_req = 1'b1;
		send_frame(40, 0);
	endtask

	// Sender stops mid-frame until the block has caught up, then resumes.
	task automatic test_sender_pause();
		set_grid(6'd4, 6'd4);
		send_frame(9, 1);
		wait_for_reports();
		send_frame(7, 0);
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_quiet_tail();
		wait_for_reports();
		idle_on     = 1'b0;
		stall_quiet = 1'b1;
		set_grid(6'd6, 6'd3);
		send_frame(36, 0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int spin;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_long_hold();
		test_sender_pause();
		test_quiet_tail();

		release_input();
		spin = 0;
		while (spin < 4000 && pending_reports.size() != 0) begin
			@(posedge clk);
			spin++;
		end
		repeat (PAD_CYC) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d reports never arrived", pending_reports.size());
			error_count++;
		end

		$display("tb_top: %0d cells sent, %0d reports checked, %0d grid settings",
			items_sent, reports_seen, settings_used);
		$display("tb_top: covered clamped sizes, single row/column, ties, hold-off, pauses");
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#400000;
		$display("tb_top: timeout");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
